[sv/minmax_uniform_quantizer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the min-max uniform quantizer
// Shared property shorthands; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MINMAX_UNIFORM_QUANTIZER_MACROS_SVH
`define MINMAX_UNIFORM_QUANTIZER_MACROS_SVH

// same-cycle implication
`define MMUQ_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MMUQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mmuq_pkg.sv]
// ----------------------------------------------------------------------------
// mmuq_pkg
// Types and constants shared by the min-max uniform quantizer.
// ----------------------------------------------------------------------------
package mmuq_pkg;

	localparam int unsigned MAX_DIM_DEF     = 64;
	localparam int unsigned SAMPLE_BITS_DEF = 16;
	localparam int unsigned CODE_BITS       = 8;
	localparam logic [CODE_BITS-1:0] LEVELS_RESET = 8'd255;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_FLUSH
	} ctrl_state_t;

	// read request from the sequencer into the quantize pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} rd_issue_t;

	// pipeline status back to the sequencer
	typedef struct packed {
		logic adv;
		logic busy;
	} pipe_status_t;

endpackage

[sv/mmuq_if.sv]
// ----------------------------------------------------------------------------
// mmuq channel interfaces
// Valid/ready channels for incoming samples and outgoing codes.
// ----------------------------------------------------------------------------
interface mmuq_sample_if import mmuq_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic                          last_sample;

	modport source (output valid, output sample_value, output last_sample, input ready);
	modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

interface mmuq_code_if import mmuq_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [CODE_BITS-1:0]          code;
	logic signed [SAMPLE_BITS-1:0] vector_min;
	logic signed [SAMPLE_BITS-1:0] vector_max;
	logic                          last_code;

	modport source (output valid, output code, output vector_min, output vector_max,
		output last_code, input ready);
	modport sink   (input valid, input code, input vector_min, input vector_max,
		input last_code, output ready);
endinterface

[sv/minmax_uniform_quantizer.sv]
// ----------------------------------------------------------------------------
// minmax_uniform_quantizer
// Buffers one vector, then emits floor(L*(v-min)/(max-min)) per element.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                       request on
//  samples   in   sample_value, last_sample                     valid & ready
//  codes     out  code, vector_min, vector_max, last_code       valid & ready
//  cfg       in   cfg_wdata -> level count                      cfg_we
//
//  Load takes one sample a cycle; the last sample (or a full store) closes it.
//  Drain reads one stored sample a cycle into a read, scale, 8-stage divide and
//  output pipeline, which gives one code a cycle; both hold while codes are taken.
//  New samples wait until the last code has left. Backpressure on codes freezes
//  the whole pipeline. Reset is immediate; the sample store is not cleared.
// ----------------------------------------------------------------------------
module minmax_uniform_quantizer import mmuq_pkg::*; #(
	parameter int unsigned MAX_DIM     = MAX_DIM_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CODE_BITS-1:0] cfg_wdata,
	mmuq_sample_if.sink          samples,
	mmuq_code_if.source          codes
);

	localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic signed [SAMPLE_BITS-1:0] wr_data;
	logic [AW-1:0]                 rd_addr;
	logic signed [SAMPLE_BITS-1:0] rd_data;
	rd_issue_t                     issue;
	pipe_status_t                  status;
	logic signed [SAMPLE_BITS-1:0] vmin, vmax;
	logic [SAMPLE_BITS:0]          divisor;
	logic                          flat;

	mmuq_ctrl #(
		.MAX_DIM     (MAX_DIM),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.status  (status),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.issue   (issue),
		.vmin    (vmin),
		.vmax    (vmax),
		.divisor (divisor),
		.flat    (flat)
	);

	mmuq_sample_store #(
		.MAX_DIM     (MAX_DIM),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (status.adv),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mmuq_quantize #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_quantize (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.issue     (issue),
		.rd_data   (rd_data),
		.vmin      (vmin),
		.vmax      (vmax),
		.divisor   (divisor),
		.flat      (flat),
		.status    (status),
		.codes     (codes)
	);

endmodule

[sv/mmuq_sample_store.sv]
// ----------------------------------------------------------------------------
// mmuq_sample_store
// Sample buffer: one write port, one registered read port with enable.
// ----------------------------------------------------------------------------
module mmuq_sample_store import mmuq_pkg::*; #(
	parameter int unsigned MAX_DIM     = MAX_DIM_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic signed [SAMPLE_BITS-1:0] wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic signed [SAMPLE_BITS-1:0] rd_data
);

	logic signed [SAMPLE_BITS-1:0] mem [MAX_DIM];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data while the pipeline is stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/mmuq_ctrl.sv]
// ----------------------------------------------------------------------------
// mmuq_ctrl
// Load/drain sequencer: fills the store, tracks min and max, issues reads.
// ----------------------------------------------------------------------------
`include "minmax_uniform_quantizer_macros.svh"

module mmuq_ctrl import mmuq_pkg::*; #(
	parameter int unsigned MAX_DIM     = MAX_DIM_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mmuq_sample_if.sink                   samples,
	input  pipe_status_t                  status,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic signed [SAMPLE_BITS-1:0] wr_data,
	output logic [AW-1:0]                 rd_addr,
	output rd_issue_t                     issue,
	output logic signed [SAMPLE_BITS-1:0] vmin,
	output logic signed [SAMPLE_BITS-1:0] vmax,
	output logic [SAMPLE_BITS:0]          divisor,
	output logic                          flat
);

	localparam int unsigned CW = $clog2(MAX_DIM + 1);
	localparam logic [CW-1:0] DIM_C = CW'(MAX_DIM);

	ctrl_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_inc;
	logic [CW-1:0] rd_idx_q;
	logic          rd_last;
	logic signed [SAMPLE_BITS-1:0] min_q, max_q;
	logic [SAMPLE_BITS:0] span_q;
	logic accept, close;

	assign accept    = samples.valid && samples.ready;
	assign count_inc = count_q + 1'b1;
	// a full store closes the vector as if flagged
	assign close     = accept && (samples.last_sample || (count_inc == DIM_C));
	assign rd_last   = (rd_idx_q == (count_q - 1'b1));

	assign wr_en   = accept;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = samples.sample_value;
	assign rd_addr = rd_idx_q[AW-1:0];

	assign vmin    = min_q;
	assign vmax    = max_q;
	// flat vector: divide zero by one
	assign flat    = (span_q == '0);
	assign divisor = flat ? (SAMPLE_BITS+1)'(1) : span_q;

	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		issue         = '0;
		unique case (state_q)
			ST_LOAD: begin
				samples.ready = 1'b1;
				if (close) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.adv) begin
					issue.valid = 1'b1;
					issue.last  = rd_last;
					if (rd_last) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				// min and max must stay put until every code has left
				if (!status.busy) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			rd_idx_q <= '0;
			min_q    <= '0;
			max_q    <= '0;
			span_q   <= '0;
		end else begin
			state_q <= state_d;
			span_q  <= {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};
			if (accept) begin
				count_q <= count_inc;
				if ((count_q == '0) || (samples.sample_value < min_q)) begin
					min_q <= samples.sample_value;
				end
				if ((count_q == '0) || (samples.sample_value > max_q)) begin
					max_q <= samples.sample_value;
				end
			end
			if ((state_q == ST_DRAIN) && status.adv) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if ((state_q == ST_FLUSH) && !status.busy) begin
				count_q  <= '0;
				rd_idx_q <= '0;
			end
		end
	end

	`MMUQ_ASSERT_IMPLY(a_count_range, 1'b1, count_q <= DIM_C, "element count beyond store depth")
	`MMUQ_ASSERT_NEXT(a_close_drain, close, state_q == ST_DRAIN, "closed vector did not start drain")
	`MMUQ_ASSERT_IMPLY(a_read_in_range, state_q == ST_DRAIN, rd_idx_q < count_q, "read past stored elements")

endmodule

[sv/mmuq_quantize.sv]
// ----------------------------------------------------------------------------
// mmuq_quantize
// Offset, scale by levels, pipelined restoring divide and output register.
// ----------------------------------------------------------------------------
`include "minmax_uniform_quantizer_macros.svh"

module mmuq_quantize import mmuq_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CODE_BITS-1:0]          cfg_wdata,
	input  rd_issue_t                     issue,
	input  logic signed [SAMPLE_BITS-1:0] rd_data,
	input  logic signed [SAMPLE_BITS-1:0] vmin,
	input  logic signed [SAMPLE_BITS-1:0] vmax,
	input  logic [SAMPLE_BITS:0]          divisor,
	input  logic                          flat,
	output pipe_status_t                  status,
	mmuq_code_if.source                   codes
);

	localparam int unsigned OW = SAMPLE_BITS + 1;
	localparam int unsigned PW = OW + CODE_BITS;

	logic [CODE_BITS-1:0] levels_q;
	logic adv;
	logic valid_s1, last_s1;
	logic [OW-1:0] off_s1;

	// divide pipeline; entry 0 is the product stage
	logic [PW-1:0]        rem_s [CODE_BITS+1];
	logic [CODE_BITS-1:0] quo_s [CODE_BITS+1];
	logic [PW-1:0]        trial_k [CODE_BITS];
	logic                 fits_k [CODE_BITS];
	logic [CODE_BITS:0]   vld_s;
	logic [CODE_BITS:0]   lst_s;

	logic                          out_valid_q;
	logic                          out_last_q;
	logic [CODE_BITS-1:0]          out_code_q;
	logic signed [SAMPLE_BITS-1:0] out_min_q, out_max_q;

	// every stage moves together; stall all while a full output register is not taken
	assign adv         = !out_valid_q || codes.ready;
	assign status.adv  = adv;
	assign status.busy = valid_s1 || (|vld_s) || out_valid_q;

	assign off_s1 = {rd_data[SAMPLE_BITS-1], rd_data} - {vmin[SAMPLE_BITS-1], vmin};

	for (genvar k = 0; k < CODE_BITS; k++) begin : g_div
		localparam int unsigned SH = CODE_BITS - 1 - k;

		assign trial_k[k] = PW'(divisor) << SH;
		assign fits_k[k]  = (rem_s[k] >= trial_k[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q    <= LEVELS_RESET;
			valid_s1    <= 1'b0;
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				levels_q <= cfg_wdata;
			end
			if (adv) begin
				valid_s1    <= issue.valid;
				vld_s       <= {vld_s[CODE_BITS-1:0], valid_s1};
				out_valid_q <= vld_s[CODE_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1    <= issue.last;
			lst_s      <= {lst_s[CODE_BITS-1:0], last_s1};
			rem_s[0]   <= flat ? '0 : (PW'(levels_q) * PW'(off_s1));
			quo_s[0]   <= '0;
			for (int k = 0; k < CODE_BITS; k++) begin
				rem_s[k+1] <= fits_k[k] ? (rem_s[k] - trial_k[k]) : rem_s[k];
				quo_s[k+1] <= {quo_s[k][CODE_BITS-2:0], fits_k[k]};
			end
			out_last_q <= lst_s[CODE_BITS];
			out_code_q <= quo_s[CODE_BITS];
			out_min_q  <= vmin;
			out_max_q  <= vmax;
		end
	end

	assign codes.valid      = out_valid_q;
	assign codes.code       = out_code_q;
	assign codes.vector_min = out_min_q;
	assign codes.vector_max = out_max_q;
	assign codes.last_code  = out_last_q;

	`MMUQ_ASSERT_IMPLY(a_divisor_nonzero, 1'b1, divisor != '0, "zero divisor reached the divider")
	`MMUQ_ASSERT_IMPLY(a_quotient_fits, vld_s[CODE_BITS], rem_s[CODE_BITS] < PW'(divisor), "code overflow in divider")

endmodule

[tb/sv/minmax_uniform_quantizer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_uniform_quantizer_checker
// Watches the sample, code and register ports of the quantizer. It rebuilds
// each vector from the accepted samples and tracks its min and max. When the
// vector closes, it queues one expected code per element. Every accepted code
// is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module minmax_uniform_quantizer_checker import mmuq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CODE_BITS-1:0] cfg_wdata,
	mmuq_sample_if               samples,
	mmuq_code_if                 codes,
	output int                   mismatches,
	output int                   outstanding,
	output int                   codes_checked
);
	typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		sample_t              vmin;
		sample_t              vmax;
		logic                 last;
	} code_word_t;

	code_word_t           expected_codes[$];
	sample_t              vector_buf[MAX_DIM_DEF];
	sample_t              vec_lo;
	sample_t              vec_hi;
	int                   fill;
	logic [CODE_BITS-1:0] levels;
	int                   bad_count;
	int                   seen_count;

	task automatic report(input string msg);
		$display("[%0t] code mismatch: %s", $time, msg);
		bad_count++;
	endtask

	// fold one sample into the open vector; on close, queue its codes
	task automatic absorb_sample(input sample_t v, input logic last);
		code_word_t w;
		int         span;
		int         off;
		int         q;
		int         k;
		if (fill == 0) begin
			vec_lo = v;
			vec_hi = v;
		end else begin
			if (v < vec_lo)
				vec_lo = v;
			if (v > vec_hi)
				vec_hi = v;
		end
		vector_buf[fill] = v;
		fill++;
		if (last || fill == MAX_DIM_DEF) begin
			span = int'(vec_hi) - int'(vec_lo);
			for (k = 0; k < fill; k++) begin
				off = int'(vector_buf[k]) - int'(vec_lo);
				q = (span == 0) ? 0 : (int'(levels) * off) / span;
				w.code = q[CODE_BITS-1:0];
				w.vmin = vec_lo;
				w.vmax = vec_hi;
				w.last = (k == fill - 1);
				expected_codes.insert(expected_codes.size(), w);
			end
			fill = 0;
		end
	endtask

	task automatic check_code();
		code_word_t want;
		seen_count++;
		if (expected_codes.size() == 0) begin
			report($sformatf("unexpected code %0d (min %0d max %0d last %0b)",
				codes.code, codes.vector_min, codes.vector_max, codes.last_code));
		end else begin
			want = expected_codes.pop_front();
			if (codes.code !== want.code)
				report($sformatf("code %0d, want %0d", codes.code, want.code));
			if (codes.vector_min !== want.vmin)
				report($sformatf("vector_min %0d, want %0d", codes.vector_min, want.vmin));
			if (codes.vector_max !== want.vmax)
				report($sformatf("vector_max %0d, want %0d", codes.vector_max, want.vmax));
			if (codes.last_code !== want.last)
				report($sformatf("last_code %0b, want %0b", codes.last_code, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_codes.delete();
			fill = 0;
			vec_lo = '0;
			vec_hi = '0;
			levels = LEVELS_RESET;
			bad_count = 0;
			seen_count = 0;
		end else begin
			if (cfg_we)
				levels = cfg_wdata;
			if (samples.valid && samples.ready)
				absorb_sample(samples.sample_value, samples.last_sample);
			if (codes.valid && codes.ready)
				check_code();
		end
		mismatches    <= bad_count;
		outstanding   <= expected_codes.size();
		codes_checked <= seen_count;
	end

endmodule

[tb/sv/minmax_uniform_quantizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_uniform_quantizer_test
// Drives vectors of Q4.12 samples into the quantizer under several level
// settings: a directed opening (extremes, flat and single-element vectors,
// levels 0, 1 and 2), then random vectors of varied shape, including full
// stores. Both channels idle in random bursts except in the final phase.
// The checker beside the block predicts and compares the codes.
// ----------------------------------------------------------------------------
module minmax_uniform_quantizer_test;
	import mmuq_pkg::*;

	typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

	typedef enum int {
		SHAPE_SCATTER,
		SHAPE_CLUSTER,
		SHAPE_FLAT,
		SHAPE_EXTREME
	} shape_t;

	localparam sample_t SAMPLE_MIN     = {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}};
	localparam sample_t SAMPLE_MAX     = ~SAMPLE_MIN;
	localparam int      WATCHDOG_LIMIT = 4000;
	localparam int      SETTLE_CYCLES  = 24;
	localparam int      RANDOM_PHASES  = 5;
	localparam int      PHASE_SAMPLES  = 16;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CODE_BITS-1:0] cfg_wdata;

	mmuq_sample_if samples ();
	mmuq_code_if   codes ();

	int mismatches;
	int outstanding;
	int codes_checked;
	bit idle_on;
	int samples_sent  = 0;
	int vectors_sent  = 0;
	int settings_used = 0;
	int fill_count    = 0;
	int stall_left    = 0;
	int quiet_cycles  = 0;

	minmax_uniform_quantizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.codes     (codes)
	);

	minmax_uniform_quantizer_checker code_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.samples       (samples),
		.codes         (codes),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.codes_checked (codes_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// code receiver: drop ready in random bursts while idling is on
	always @(posedge clk) begin
		if (!arst_n) begin
			codes.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left  <= stall_left - 1;
			codes.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left  <= $urandom_range(0, 7);
			codes.ready <= 1'b0;
		end else begin
			codes.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (samples.valid && samples.ready) || (codes.valid && codes.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles, %0d codes outstanding",
				WATCHDOG_LIMIT, outstanding);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// hold the request until accepted; a gap may come first
	task automatic push_sample(input sample_t v, input logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			samples.valid        <= 1'b0;
			samples.sample_value <= sample_t'($urandom);
			samples.last_sample  <= 1'($urandom);
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		samples.valid        <= 1'b1;
		samples.sample_value <= v;
		samples.last_sample  <= last;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		samples_sent++;
		fill_count++;
		if (last || fill_count == MAX_DIM_DEF) begin
			vectors_sent++;
			fill_count = 0;
		end
	endtask

	task automatic send_vector(input int len, input shape_t shape, input bit tag_last);
		sample_t base;
		sample_t v;
		int      k;
		base = sample_t'($urandom);
		for (k = 0; k < len; k++) begin
			case (shape)
				SHAPE_CLUSTER: v = base + sample_t'($urandom_range(0, 15));
				SHAPE_FLAT:    v = base;
				SHAPE_EXTREME: begin
					case ($urandom_range(0, 3))
						0:       v = SAMPLE_MIN;
						1:       v = SAMPLE_MAX;
						2:       v = '0;
						default: v = sample_t'($urandom);
					endcase
				end
				default:       v = sample_t'($urandom);
			endcase
			push_sample(v, tag_last && (k == len - 1));
		end
	endtask

	// drop the request, wait out every pending code and the pipeline tail
	task automatic drain_codes();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_levels(input logic [CODE_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int phase;
		int phase_start;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		samples.valid        <= 1'b0;
		samples.sample_value <= '0;
		samples.last_sample  <= 1'b0;
		idle_on              <= 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset levels: full-scale extremes, a flat vector, a lone element
		push_sample(SAMPLE_MIN, 1'b0);
		push_sample(SAMPLE_MAX, 1'b0);
		push_sample(sample_t'(0), 1'b0);
		push_sample(sample_t'(-1), 1'b0);
		push_sample(sample_t'(1), 1'b1);
		push_sample(sample_t'(1234), 1'b0);
		push_sample(sample_t'(1234), 1'b0);
		push_sample(sample_t'(1234), 1'b1);
		push_sample(sample_t'(-5), 1'b1);

		// degenerate level counts, then the smallest legal one
		drain_codes();
		set_levels(8'd0);
		push_sample(sample_t'(-100), 1'b0);
		push_sample(sample_t'(0), 1'b0);
		push_sample(sample_t'(100), 1'b1);
		drain_codes();
		set_levels(8'd1);
		push_sample(sample_t'(-100), 1'b0);
		push_sample(sample_t'(0), 1'b0);
		push_sample(sample_t'(99), 1'b0);
		push_sample(sample_t'(100), 1'b1);
		drain_codes();
		set_levels(8'd2);
		push_sample(sample_t'(-3), 1'b0);
		push_sample(sample_t'(-1), 1'b0);
		push_sample(sample_t'(0), 1'b0);
		push_sample(sample_t'(2), 1'b0);
		push_sample(sample_t'(3), 1'b1);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_codes();
			case (phase)
				0:       set_levels(8'd255);
				1:       set_levels(8'd2);
				default: set_levels(8'($urandom_range(2, 255)));
			endcase
			if (phase == RANDOM_PHASES - 1)
				idle_on <= 1'b0;
			phase_start = samples_sent;
			// a store that fills without a last flag, and one closed on its last slot
			if (phase == 0)
				send_vector(MAX_DIM_DEF, SHAPE_SCATTER, 1'b0);
			if (phase == 2)
				send_vector(MAX_DIM_DEF, SHAPE_CLUSTER, 1'b1);
			while (samples_sent - phase_start < PHASE_SAMPLES)
				send_vector($urandom_range(1, 10), shape_t'($urandom_range(0, 3)), 1'b1);
		end

		drain_codes();
		$display("sent %0d samples in %0d vectors under %0d level settings",
			samples_sent, vectors_sent, settings_used);
		$display("compared %0d codes, %0d mismatches", codes_checked, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
